// ----- src/hlep_pkg.sv -----
// Package: shared types, constants and hex decode helpers for the hex line parser.
`timescale 1ns / 1ps
package hlep_pkg;

  localparam int unsigned LINE_LEN = 32;
  localparam int unsigned LEN_W    = $clog2(LINE_LEN + 1);

  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_DEL = 8'h7f;

  localparam logic [15:0] LAST_WORD_RST = 16'h0410;

  // one stack entry: parse value so far plus the stop flag
  typedef struct packed {
    logic        stop;
    logic [15:0] value;
  } entry_t;

  // shift controls fanned out to every stack stage
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  function automatic logic is_hex_char(input logic [7:0] c);
    logic [7:0] lc;
    begin
      lc = c | 8'h20;
      if (c < 8'h30) begin
        return 1'b0;
      end
      if (c <= 8'h39) begin
        return 1'b1;
      end
      return (lc >= 8'h61) && (lc <= 8'h66);
    end
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] d;
    begin
      u = c & 8'h5f;
      d = u - 8'h37;
      if (u < 8'h40) begin
        return u[3:0];
      end
      return d[3:0];
    end
  endfunction

endpackage

// ----- src/hlep_cell.sv -----
// One stack stage: takes the newer neighbor on push, the older neighbor on pop.
`timescale 1ns / 1ps
module hlep_cell (
  input  logic                clk,
  input  hlep_pkg::stack_ctl_t ctl,
  input  hlep_pkg::entry_t    newer_in,
  input  hlep_pkg::entry_t    older_in,
  output hlep_pkg::entry_t    entry_out
);
  import hlep_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push) begin
      entry_nxt = newer_in;
    end else if (ctl.pop) begin
      entry_nxt = older_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;

endmodule

// ----- src/hlep_stack.sv -----
// Line stack built as a chain of shifting stages; the top is always stage 0.
`timescale 1ns / 1ps
module hlep_stack (
  input  logic                 clk,
  input  hlep_pkg::stack_ctl_t ctl,
  input  hlep_pkg::entry_t     push_entry,
  output hlep_pkg::entry_t     top_entry
);
  import hlep_pkg::*;

  entry_t stage_q [LINE_LEN];

  for (genvar i = 0; i < LINE_LEN; i++) begin : g_stage
    entry_t newer;
    entry_t older;

    if (i == 0) begin : g_head
      assign newer = push_entry;
    end else begin : g_body
      assign newer = stage_q[i-1];
    end

    if (i == LINE_LEN - 1) begin : g_tail
      assign older = '0;
    end else begin : g_mid
      assign older = stage_q[i+1];
    end

    hlep_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .newer_in  (newer),
      .older_in  (older),
      .entry_out (stage_q[i])
    );
  end

  assign top_entry = stage_q[0];

endmodule

// ----- src/hex_line_entry_parser_core.sv -----
// Top level: hex line entry parser with echo, line stack and output register.
// Each result word is registered and appears on the out_ side in the cycle after its input word is accepted.
// Throughput: one word per cycle unless the receiver stalls; the top of stack always sits
// in stage 0 of the shifting stack, so each character needs only that register and one shift.
// Reset (rst_n low, synchronous): line empty, last word 0x0410, output invalid.
// Stack contents are not reset; an entry is only read after it was pushed.
`timescale 1ns / 1ps
module hex_line_entry_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_char
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] echo_char, [23:8] word_value
  output logic        out_tlast,  // line_done
  output logic        out_tuser   // used_previous
);
  import hlep_pkg::*;

  logic             accept;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      last_word_r, last_word_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       echo_r;
  logic [15:0]      word_r;
  logic             done_r, prev_r;
  logic [15:0]      word_nxt;
  logic             done_nxt, prev_nxt;

  stack_ctl_t ctl;
  entry_t     top_entry;
  entry_t     top_eff;
  entry_t     push_entry;
  logic [15:0] shifted;

  // output register frees up whenever downstream takes the word
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // empty line parses from zero
  assign top_eff = (len_r != '0) ? top_entry : '0;
  // shift in the new nibble, upper digits fall off (16-bit wrap)
  assign shifted = {top_eff.value[11:0], hex_digit(in_tdata)};

  always_comb begin
    if (top_eff.stop) begin
      push_entry = top_eff;
    end else if (is_hex_char(in_tdata)) begin
      push_entry = '{stop: 1'b0, value: shifted};
    end else begin
      push_entry = '{stop: 1'b1, value: top_eff.value};
    end
  end

  always_comb begin
    len_nxt       = len_r;
    last_word_nxt = last_word_r;
    done_nxt      = 1'b0;
    prev_nxt      = 1'b0;
    word_nxt      = '0;
    ctl           = '{push: 1'b0, pop: 1'b0};
    if (accept) begin
      if (in_tdata == CHAR_CR) begin
        done_nxt = 1'b1;
        len_nxt  = '0;
        if (len_r == '0) begin
          word_nxt = last_word_r;
          prev_nxt = 1'b1;
        end else begin
          word_nxt      = top_entry.value;
          last_word_nxt = top_entry.value;
        end
      end else if (in_tdata == CHAR_BS || in_tdata == CHAR_DEL) begin
        if (len_r != '0) begin
          len_nxt = len_r - 1'b1;
          ctl.pop = 1'b1;
        end
      end else begin
        ctl.push = 1'b1;
        if (len_r == LEN_W'(LINE_LEN - 1)) begin
          // line full: ends at once with the new top
          done_nxt      = 1'b1;
          word_nxt      = push_entry.value;
          last_word_nxt = push_entry.value;
          len_nxt       = '0;
        end else begin
          len_nxt = len_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  hlep_stack u_stack (
    .clk        (clk),
    .ctl        (ctl),
    .push_entry (push_entry),
    .top_entry  (top_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      last_word_r <= LAST_WORD_RST;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      last_word_r <= last_word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_r <= in_tdata;
      word_r <= word_nxt;
      done_r <= done_nxt;
      prev_r <= prev_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {word_r, echo_r};
  assign out_tlast  = done_r;
  assign out_tuser  = prev_r;

  // line count never runs past a full line
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < LEN_W'(LINE_LEN))
    else $error("line length out of range");

  // reuse of last word only on a line end
  a_prev_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && prev_r |-> done_r)
    else $error("used_previous without line end");

  // word field is zero unless the line ended
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> word_r == '0)
    else $error("word_value set mid-line");

  // carriage return always empties the line
  a_cr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tdata == CHAR_CR |=> len_r == '0 && done_r)
    else $error("line not cleared after CR");

  // reused word matches the held last word
  a_prev_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tdata == CHAR_CR && len_r == '0 |=> word_r == $past(last_word_r))
    else $error("empty line did not give last word");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for hex_line_entry_parser_core: directed edits plus random lines under idle/stall mixes.
`timescale 1ns / 1ps
module tb;
  import hlep_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_CHARS  = 1850;
  localparam int unsigned DRAIN_WAIT  = 8;

  // one echoed word as the block should give it
  typedef struct {
    logic [7:0]  echo;
    logic        done;
    logic [15:0] word;
    logic        prev;
  } line_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_char
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] echo_char, [23:8] word_value
  logic        out_tlast;  // line_done
  logic        out_tuser;  // used_previous

  hex_line_entry_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // shadow of the line state
  entry_t      line_stack [LINE_LEN];
  int unsigned line_len;
  logic [15:0] last_word_q;

  line_result_t pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  int unsigned chars_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned lines_ended;
  int unsigned full_lines;
  int unsigned reused_words;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure, rerolled each cycle
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit char_is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c >= "a") begin
      v = c - "a" + 8'd10;
    end else begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  // advance the shadow line state by one character and return the expected word
  function automatic line_result_t predict_char(input logic [7:0] c);
    line_result_t r;
    entry_t       top;
    entry_t       nxt;
    r = '{echo: c, done: 1'b0, word: 16'h0000, prev: 1'b0};
    if (c == CHAR_CR) begin
      r.done = 1'b1;
      if (line_len == 0) begin
        r.word = last_word_q;
        r.prev = 1'b1;
        reused_words++;
      end else begin
        r.word      = line_stack[line_len - 1].value;
        last_word_q = r.word;
      end
      line_len = 0;
      lines_ended++;
    end else if (c == CHAR_BS || c == CHAR_DEL) begin
      if (line_len != 0) begin
        line_len--;
      end
    end else begin
      top = (line_len != 0) ? line_stack[line_len - 1] : '0;
      if (top.stop) begin
        nxt = top;                       // parse already stopped: copy
      end else if (char_is_hex(c)) begin
        nxt.stop  = 1'b0;
        nxt.value = {top.value[11:0], nibble_of(c)};  // wraps to 16 bits
      end else begin
        nxt.stop  = 1'b1;
        nxt.value = top.value;
      end
      line_stack[line_len] = nxt;
      line_len++;
      if (line_len == LINE_LEN) begin   // line full ends it at once
        r.done      = 1'b1;
        r.word      = nxt.value;
        last_word_q = nxt.value;
        line_len    = 0;
        lines_ended++;
        full_lines++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch in word %0d, %s: got 0x%0h, expected 0x%0h", results_seen, field,
             got, want);
    mismatch_count++;
  endtask

  // checker: pop on each output word, then predict on each accepted input word
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[7:0] !== want.echo) report_mismatch("echo_char", out_tdata[7:0], want.echo);
          if (out_tlast !== want.done) report_mismatch("line_done", out_tlast, want.done);
          if (out_tdata[23:8] !== want.word) begin
            report_mismatch("word_value", out_tdata[23:8], want.word);
          end
          if (out_tuser !== want.prev) report_mismatch("used_previous", out_tuser, want.prev);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_char(in_tdata));
      end
    end
  end

  // send one character; valid stays high into the next call unless an idle gap is rolled
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // every accepted word has come back out
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (results_seen < chars_sent) @(posedge clk);
  endtask

  // empty lines: last word reused, backspace/delete on nothing
  task automatic test_empty_line();
    send_char(CHAR_CR);
    send_char(CHAR_BS);
    send_char(CHAR_DEL);
    send_char(CHAR_CR);
  endtask

  // mixed case digits, stop on non-hex, pops restore the earlier parse, 16-bit wrap
  task automatic test_edit_and_stop();
    send_string("12aF9");
    send_char("x");
    send_char("7");
    send_char(CHAR_BS);
    send_char(CHAR_DEL);
    send_char("2");
    send_char(CHAR_CR);
  endtask

  // first character not hex gives 0, which then becomes the reused word
  task automatic test_non_hex_first();
    send_char(8'h00);
    send_char(8'hff);
    send_char(CHAR_CR);
    send_char(CHAR_CR);
  endtask

  function automatic logic [7:0] pick_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7e));
    while (char_is_hex(c)) c = 8'($urandom_range(8'h20, 8'h7e));
    return c;
  endfunction

  // one typed character: mostly digits, some edits and stray characters
  function automatic logic [7:0] pick_typed();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 78) return pick_hex();
    if (roll < 84) return CHAR_BS;
    if (roll < 88) return CHAR_DEL;
    return pick_non_hex();
  endfunction

  task automatic send_random_line();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 8) begin
      if ($urandom_range(1)) send_char(CHAR_BS);
      send_char(CHAR_CR);
    end else if (kind < 20) begin
      // long run without CR so the line fills up
      n = $urandom_range(LINE_LEN, LINE_LEN + 10);
      repeat (n) send_char(($urandom_range(9) == 0) ? pick_non_hex() : pick_hex());
    end else if (kind < 30) begin
      // raw noise, any byte value
      n = $urandom_range(1, 8);
      repeat (n) send_char(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) send_char(pick_typed());
      send_char(CHAR_CR);
    end
  endtask

  task automatic test_random_lines(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_chars);
    int unsigned stop_at;
    int unsigned paused;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = chars_sent + n_chars;
    paused         = 0;
    while (chars_sent < stop_at) begin
      send_random_line();
      // hold off once per phase until the pipe is empty
      if (!paused && chars_sent + n_chars / 2 >= stop_at) begin
        wait_results_drained();
        paused = 1;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    chars_sent     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    lines_ended    = 0;
    full_lines     = 0;
    reused_words   = 0;
    line_len       = 0;
    last_word_q    = LAST_WORD_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_line();
    test_edit_and_stop();
    test_non_hex_first();
    test_random_lines(0, 0, RAND_CHARS / 4);
    test_random_lines(85, 0, RAND_CHARS / 4);
    test_random_lines(0, 85, RAND_CHARS / 4);
    test_random_lines(7, 7, RAND_CHARS / 4);

    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d characters, %0d words checked, %0d lines ended", chars_sent,
             results_seen, lines_ended);
    $display("of those, %0d by a full line and %0d reusing the last word", full_lines,
             reused_words);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hlep_pkg.sv
src/hlep_cell.sv
src/hlep_stack.sv
src/hex_line_entry_parser_core.sv
tb/sv/tb.sv
